// ===== rtl/core/pthc_pkg.sv =====
// shared constants, register codes and sideband types of the pth compensation block
package pthc_pkg;

  // width of the pressure quotient, one divider stage per quotient bit
  localparam int unsigned DivBits = 64;

  // front pipeline (stage 1 .. stage 13) and back pipeline (after divider) depths
  localparam int unsigned FrontStages = 13;
  localparam int unsigned BackStages  = 5;
  localparam int unsigned PipeLat     = FrontStages + DivBits + BackStages;

  // configuration register indexes
  typedef enum logic [2:0] {
    CFG_TEMP     = 3'd0,
    CFG_PRESS_A  = 3'd1,
    CFG_PRESS_B  = 3'd2,
    CFG_PRESS_P9 = 3'd3,
    CFG_HUM      = 3'd4
  } cfg_reg_t;

  // formula constants
  localparam logic signed [63:0] PressOfs   = 64'sd128000;
  localparam logic signed [63:0] PressBias  = 64'sd140737488355328; // 2^47
  localparam logic signed [63:0] PressFull  = 64'sd1048576;
  localparam logic signed [63:0] PressScale = 64'sd3125;
  localparam logic signed [31:0] HumOfs     = 32'sd76800;
  localparam logic signed [31:0] HumRound   = 32'sd16384;
  localparam logic signed [31:0] HumZBias   = 32'sd32768;
  localparam logic signed [31:0] HumWBias   = 32'sd2097152;
  localparam logic signed [31:0] HumWRound  = 32'sd8192;
  localparam logic signed [31:0] HumMax     = 32'sd419430400;
  localparam logic signed [31:0] TempRound  = 32'sd128;

  // values that ride along with the pressure division
  typedef struct packed {
    logic        zero;   // divisor term was zero
    logic        neg;    // quotient must be negated
    logic [15:0] temp;   // finished temperature
    logic [13:0] hum;    // finished humidity
  } pthc_side_t;

endpackage

// ===== rtl/core/pthc_div.sv =====
// pipelined unsigned restoring divider, one quotient bit per stage
module pthc_div
  import pthc_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_vld,
  input  logic [DivBits-1:0] in_num,
  input  logic [DivBits-1:0] in_den,
  input  pthc_side_t         in_side,
  output logic               out_vld,
  output logic [DivBits-1:0] out_quo,
  output pthc_side_t         out_side
);

  typedef struct packed {
    logic [DivBits-1:0] rem;
    logic [DivBits-1:0] quo;
    logic [DivBits-1:0] den;
    pthc_side_t         side;
  } div_stage_t;

  logic [DivBits-1:0] vld_r;
  div_stage_t         stg_r   [DivBits];
  div_stage_t         stg_in  [DivBits];
  div_stage_t         stg_nxt [DivBits];

  // stage inputs: the incoming word, then the previous stage
  always_comb begin
    stg_in[0].rem  = '0;
    stg_in[0].quo  = in_num;
    stg_in[0].den  = in_den;
    stg_in[0].side = in_side;
    for (int i = 1; i < DivBits; i++) begin
      stg_in[i] = stg_r[i-1];
    end
  end

  // one shift and trial subtract per stage
  always_comb begin
    logic [DivBits-1:0] sh;
    for (int i = 0; i < DivBits; i++) begin
      sh = {stg_in[i].rem[DivBits-2:0], stg_in[i].quo[DivBits-1]};
      stg_nxt[i]     = stg_in[i];
      stg_nxt[i].quo = {stg_in[i].quo[DivBits-2:0], 1'b0};
      if (sh >= stg_in[i].den) begin
        stg_nxt[i].rem    = sh - stg_in[i].den;
        stg_nxt[i].quo[0] = 1'b1;
      end else begin
        stg_nxt[i].rem = sh;
      end
    end
  end

  // valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[DivBits-2:0], in_vld};
    end
  end

  // stage payload
  always_ff @(posedge clk) begin
    for (int i = 0; i < DivBits; i++) begin
      stg_r[i] <= stg_nxt[i];
    end
  end

  assign out_vld  = vld_r[DivBits-1];
  assign out_quo  = stg_r[DivBits-1].quo;
  assign out_side = stg_r[DivBits-1].side;

endmodule

// ===== rtl/core/pth_sensor_compensation.sv =====
// pressure, temperature and humidity integer compensation pipeline
//
// channel | ports                                  | handshake
// --------+----------------------------------------+-------------------------------
// input   | in_raw_pressure/temperature/humidity   | start && !busy takes a word
// result  | out_temp_centi, out_pressure_pa, ..    | out_valid strobe, one cycle
// config  | cfg_index, cfg_data                    | cfg_valid && cfg_ready
//
// a new word is taken every cycle while busy is low; each result passes through the
// 13 front stages, the 64 stages of the pressure divider and the 5 back stages.
// the 64-bit pressure division, one quotient bit per stage, sets the latency.
// reset is synchronous and clears all valid bits; busy is high only in reset.
// the receiver cannot stall, so nothing in the pipeline ever waits.
module pth_sensor_compensation
  import pthc_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic [19:0]        in_raw_pressure,
  input  logic [19:0]        in_raw_temperature,
  input  logic [15:0]        in_raw_humidity,
  output logic               out_valid,
  output logic signed [15:0] out_temp_centi,
  output logic [31:0]        out_pressure_pa,
  output logic [13:0]        out_humidity_centi,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [2:0]         cfg_index,
  input  logic [63:0]        cfg_data
);

  localparam int unsigned TcDepth = 10; // stage 4 .. stage 13
  localparam int unsigned PdDepth = 5;  // stage 9 .. stage 13

  // calibration registers
  logic [47:0] cal_temp_r;
  logic [63:0] cal_pa_r;
  logic [63:0] cal_pb_r;
  logic [15:0] cal_p9_r;
  logic [63:0] cal_hum_r;

  assign cfg_ready = 1'b1;
  assign busy      = ~rst_n;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cal_temp_r <= '0;
      cal_pa_r   <= '0;
      cal_pb_r   <= '0;
      cal_p9_r   <= '0;
      cal_hum_r  <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_reg_t'(cfg_index))
        CFG_TEMP:     cal_temp_r <= cfg_data[47:0];
        CFG_PRESS_A:  cal_pa_r   <= cfg_data;
        CFG_PRESS_B:  cal_pb_r   <= cfg_data;
        CFG_PRESS_P9: cal_p9_r   <= cfg_data[15:0];
        CFG_HUM:      cal_hum_r  <= cfg_data;
        default: ;
      endcase
    end
  end

  // coefficient slices
  logic signed [31:0] t1_s, t2_s, t3_s;
  logic signed [63:0] p1_s, p2_s, p3_s, p4_s, p5_s, p6_s, p7_s, p8_s, p9_s;
  logic signed [31:0] h1_s, h2_s, h3_s, h4_s, h5_s, h6_s;

  assign t1_s = $signed({16'd0, cal_temp_r[15:0]});
  assign t2_s = $signed({{16{cal_temp_r[31]}}, cal_temp_r[31:16]});
  assign t3_s = $signed({{16{cal_temp_r[47]}}, cal_temp_r[47:32]});
  assign p1_s = $signed({48'd0, cal_pa_r[15:0]});
  assign p2_s = $signed({{48{cal_pa_r[31]}}, cal_pa_r[31:16]});
  assign p3_s = $signed({{48{cal_pa_r[47]}}, cal_pa_r[47:32]});
  assign p4_s = $signed({{48{cal_pa_r[63]}}, cal_pa_r[63:48]});
  assign p5_s = $signed({{48{cal_pb_r[15]}}, cal_pb_r[15:0]});
  assign p6_s = $signed({{48{cal_pb_r[31]}}, cal_pb_r[31:16]});
  assign p7_s = $signed({{48{cal_pb_r[47]}}, cal_pb_r[47:32]});
  assign p8_s = $signed({{48{cal_pb_r[63]}}, cal_pb_r[63:48]});
  assign p9_s = $signed({{48{cal_p9_r[15]}}, cal_p9_r});
  assign h1_s = $signed({24'd0, cal_hum_r[7:0]});
  assign h2_s = $signed({{16{cal_hum_r[23]}}, cal_hum_r[23:8]});
  assign h3_s = $signed({24'd0, cal_hum_r[31:24]});
  assign h4_s = $signed({{20{cal_hum_r[43]}}, cal_hum_r[43:32]});
  assign h5_s = $signed({{20{cal_hum_r[55]}}, cal_hum_r[55:44]});
  assign h6_s = $signed({{24{cal_hum_r[63]}}, cal_hum_r[63:56]});

  // front valid bits, index 0 is stage 1
  logic [FrontStages-1:0] fv_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fv_r <= '0;
    end else begin
      fv_r <= {fv_r[FrontStages-2:0], start & ~busy};
    end
  end

  // stage 1: temperature differences and first products
  logic signed [31:0] ta_w, tb_w, hx_w;
  logic signed [31:0] s1_pa_r, s1_bb_r, s1_hx_r;
  logic [19:0]        s1_rp_r;

  assign ta_w = $signed({15'd0, in_raw_temperature[19:3]}) - (t1_s <<< 1);
  assign tb_w = $signed({16'd0, in_raw_temperature[19:4]}) - t1_s;
  assign hx_w = $signed({2'd0, in_raw_humidity, 14'd0}) - (h4_s <<< 20) + HumRound;

  always_ff @(posedge clk) begin
    s1_pa_r <= ta_w * t2_s;
    s1_bb_r <= tb_w * tb_w;
    s1_hx_r <= hx_w;
    s1_rp_r <= in_raw_pressure;
  end

  // stage 2: second temperature term product
  logic signed [31:0] tv1_w, bb12_w;
  logic signed [31:0] s2_tv1_r, s2_m_r, s2_hx_r;
  logic [19:0]        s2_rp_r;

  assign tv1_w  = s1_pa_r >>> 11;
  assign bb12_w = s1_bb_r >>> 12;

  always_ff @(posedge clk) begin
    s2_tv1_r <= tv1_w;
    s2_m_r   <= bb12_w * t3_s;
    s2_hx_r  <= s1_hx_r;
    s2_rp_r  <= s1_rp_r;
  end

  // stage 3: fine temperature
  logic signed [31:0] tv2_w;
  logic signed [31:0] s3_tf_r, s3_hx_r;
  logic [19:0]        s3_rp_r;

  assign tv2_w = s2_m_r >>> 14;

  always_ff @(posedge clk) begin
    s3_tf_r <= s2_tv1_r + tv2_w;
    s3_hx_r <= s2_hx_r;
    s3_rp_r <= s2_rp_r;
  end

  // stage 4: temperature output, pressure and humidity offset products
  logic signed [31:0] tc_w, vh_w;
  logic signed [32:0] v1n_w;
  logic signed [63:0] v1_w;
  logic signed [63:0] s4_v1sq_r, s4_v1p5_r, s4_v1p2_r;
  logic signed [31:0] s4_h5v_r, s4_vh6_r, s4_vh3_r, s4_hx_r;
  logic [19:0]        s4_rp_r;
  logic [15:0]        tc_r [TcDepth];

  // pressure offset fits in 33 bits, so the square stays near 33 by 33
  assign tc_w  = ((s3_tf_r <<< 2) + s3_tf_r + TempRound) >>> 8;
  assign v1n_w = $signed({s3_tf_r[31], s3_tf_r}) - 33'(PressOfs);
  assign v1_w  = 64'(v1n_w);
  assign vh_w  = s3_tf_r - HumOfs;

  always_ff @(posedge clk) begin
    s4_v1sq_r <= v1n_w * v1n_w;
    s4_v1p5_r <= v1_w * p5_s;
    s4_v1p2_r <= v1_w * p2_s;
    s4_h5v_r  <= h5_s * vh_w;
    s4_vh6_r  <= vh_w * h6_s;
    s4_vh3_r  <= vh_w * h3_s;
    s4_hx_r   <= s3_hx_r;
    s4_rp_r   <= s3_rp_r;
  end

  // temperature result delay line
  always_ff @(posedge clk) begin
    tc_r[0] <= tc_w[15:0];
    for (int i = 1; i < TcDepth; i++) begin
      tc_r[i] <= tc_r[i-1];
    end
  end

  // stage 5: squared offset times coefficients, humidity x, y, z
  logic signed [63:0] s5_v2a_r, s5_v1a_r, s5_v1p5_r, s5_v1p2_r;
  logic signed [31:0] s5_x_r, s5_y_r, s5_z_r;
  logic [19:0]        s5_rp_r;

  always_ff @(posedge clk) begin
    s5_v2a_r  <= s4_v1sq_r * p6_s;
    s5_v1a_r  <= s4_v1sq_r * p3_s;
    s5_v1p5_r <= s4_v1p5_r;
    s5_v1p2_r <= s4_v1p2_r;
    s5_x_r    <= (s4_hx_r - s4_h5v_r) >>> 15;
    s5_y_r    <= s4_vh6_r >>> 10;
    s5_z_r    <= (s4_vh3_r >>> 11) + HumZBias;
    s5_rp_r   <= s4_rp_r;
  end

  // stage 6: pressure sums, humidity y*z
  logic signed [63:0] s6_v2_r, s6_vs_r;
  logic signed [31:0] s6_yz_r, s6_x_r;
  logic [19:0]        s6_rp_r;

  always_ff @(posedge clk) begin
    s6_v2_r <= s5_v2a_r + (s5_v1p5_r <<< 17) + (p4_s <<< 35);
    s6_vs_r <= PressBias + (s5_v1a_r >>> 8) + (s5_v1p2_r <<< 12);
    s6_yz_r <= s5_y_r * s5_z_r;
    s6_x_r  <= s5_x_r;
    s6_rp_r <= s5_rp_r;
  end

  // stage 7: divisor product, numerator base, humidity w
  logic signed [63:0] pn_w;
  logic signed [63:0] s7_pr_r, s7_n0_r;
  logic signed [31:0] s7_w_r, s7_x_r;

  assign pn_w = PressFull - $signed({44'd0, s6_rp_r});

  always_ff @(posedge clk) begin
    s7_pr_r <= s6_vs_r * p1_s;
    s7_n0_r <= (pn_w <<< 31) - s6_v2_r;
    s7_w_r  <= (s6_yz_r >>> 10) + HumWBias;
    s7_x_r  <= s6_x_r;
  end

  // stage 8: divisor, numerator, humidity w*h2
  logic signed [63:0] s8_den_r, s8_num_r;
  logic signed [31:0] s8_wh_r, s8_x_r;

  always_ff @(posedge clk) begin
    s8_den_r <= s7_pr_r >>> 33;
    s8_num_r <= s7_n0_r * PressScale;
    s8_wh_r  <= s7_w_r * h2_s;
    s8_x_r   <= s7_x_r;
  end

  // stage 9: operand magnitudes and signs, humidity scale
  logic [63:0]        an_r   [PdDepth];
  logic [63:0]        ad_r   [PdDepth];
  logic               zero_r [PdDepth];
  logic               neg_r  [PdDepth];
  logic signed [31:0] s9_w2_r, s9_x_r;

  always_ff @(posedge clk) begin
    an_r[0]   <= s8_num_r[63] ? 64'(-s8_num_r) : s8_num_r;
    ad_r[0]   <= s8_den_r[63] ? 64'(-s8_den_r) : s8_den_r;
    zero_r[0] <= (s8_den_r == '0);
    neg_r[0]  <= s8_num_r[63] ^ s8_den_r[63];
    for (int i = 1; i < PdDepth; i++) begin
      an_r[i]   <= an_r[i-1];
      ad_r[i]   <= ad_r[i-1];
      zero_r[i] <= zero_r[i-1];
      neg_r[i]  <= neg_r[i-1];
    end
    s9_w2_r <= (s8_wh_r + HumWRound) >>> 14;
    s9_x_r  <= s8_x_r;
  end

  // stage 10: humidity product
  logic signed [31:0] s10_vx_r;

  always_ff @(posedge clk) begin
    s10_vx_r <= s9_x_r * s9_w2_r;
  end

  // stage 11: humidity square
  logic signed [31:0] s15_w;
  logic signed [31:0] s11_sq_r, s11_vx_r;

  assign s15_w = s10_vx_r >>> 15;

  always_ff @(posedge clk) begin
    s11_sq_r <= s15_w * s15_w;
    s11_vx_r <= s10_vx_r;
  end

  // stage 12: humidity correction product
  logic signed [31:0] sq7_w;
  logic signed [31:0] s12_q_r, s12_vx_r;

  assign sq7_w = s11_sq_r >>> 7;

  always_ff @(posedge clk) begin
    s12_q_r  <= sq7_w * h1_s;
    s12_vx_r <= s11_vx_r;
  end

  // stage 13: humidity clamp and scaling to 0.01 %RH
  logic signed [31:0] hv_w;
  logic [31:0]        hc_w;
  logic [23:0]        hp_w;
  logic [13:0]        s13_hum_r;

  assign hv_w = s12_vx_r - (s12_q_r >>> 4);

  always_comb begin
    if (hv_w[31]) begin
      hc_w = '0;
    end else if (hv_w > HumMax) begin
      hc_w = HumMax;
    end else begin
      hc_w = hv_w;
    end
  end

  assign hp_w = 24'(hc_w[28:12]) * 24'd100 + 24'd512;

  always_ff @(posedge clk) begin
    s13_hum_r <= hp_w[23:10];
  end

  // pressure division
  pthc_side_t         div_side_in, div_side;
  logic               div_vld;
  logic [DivBits-1:0] div_quo;

  assign div_side_in = '{zero: zero_r[PdDepth-1], neg: neg_r[PdDepth-1],
                         temp: tc_r[TcDepth-1], hum: s13_hum_r};

  pthc_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_vld   (fv_r[FrontStages-1]),
    .in_num   (an_r[PdDepth-1]),
    .in_den   (ad_r[PdDepth-1]),
    .in_side  (div_side_in),
    .out_vld  (div_vld),
    .out_quo  (div_quo),
    .out_side (div_side)
  );

  // back valid bits
  logic [BackStages-2:0] bv_r;
  logic                  out_vld_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bv_r      <= '0;
      out_vld_r <= 1'b0;
    end else begin
      bv_r      <= {bv_r[BackStages-3:0], div_vld};
      out_vld_r <= bv_r[BackStages-2];
    end
  end

  // back 1: quotient sign
  logic signed [63:0] bk1_q_r;
  pthc_side_t         bk1_side_r;

  always_ff @(posedge clk) begin
    bk1_q_r    <= div_side.neg ? 64'(-div_quo) : div_quo;
    bk1_side_r <= div_side;
  end

  // back 2: partial products of the squared term, p8 term
  logic signed [63:0] a13_w;
  logic [63:0]        bk2_al2_r;
  logic [31:0]        bk2_ahl_r;
  logic signed [63:0] bk2_e2p_r, bk2_q_r;
  pthc_side_t         bk2_side_r;

  assign a13_w = bk1_q_r >>> 13;

  always_ff @(posedge clk) begin
    bk2_al2_r  <= {32'd0, a13_w[31:0]} * {32'd0, a13_w[31:0]};
    bk2_ahl_r  <= a13_w[63:32] * a13_w[31:0];
    bk2_e2p_r  <= bk1_q_r * p8_s;
    bk2_q_r    <= bk1_q_r;
    bk2_side_r <= bk1_side_r;
  end

  // back 3: squared term modulo 2^64
  logic signed [63:0] bk3_aa_r, bk3_e2p_r, bk3_q_r;
  pthc_side_t         bk3_side_r;

  always_ff @(posedge clk) begin
    bk3_aa_r   <= bk2_al2_r + {bk2_ahl_r[30:0], 33'd0};
    bk3_e2p_r  <= bk2_e2p_r;
    bk3_q_r    <= bk2_q_r;
    bk3_side_r <= bk2_side_r;
  end

  // back 4: p9 term
  logic signed [63:0] bk4_e1p_r, bk4_e2p_r, bk4_q_r;
  pthc_side_t         bk4_side_r;

  always_ff @(posedge clk) begin
    bk4_e1p_r  <= bk3_aa_r * p9_s;
    bk4_e2p_r  <= bk3_e2p_r;
    bk4_q_r    <= bk3_q_r;
    bk4_side_r <= bk3_side_r;
  end

  // back 5: final pressure sum, output register
  logic signed [63:0] ps_w;
  logic signed [15:0] out_temp_r;
  logic [31:0]        out_press_r;
  logic [13:0]        out_hum_r;

  assign ps_w = ((bk4_q_r + (bk4_e1p_r >>> 25) + (bk4_e2p_r >>> 19)) >>> 8) + (p7_s <<< 4);

  always_ff @(posedge clk) begin
    out_temp_r  <= bk4_side_r.temp;
    out_press_r <= bk4_side_r.zero ? 32'd0 : ps_w[39:8];
    out_hum_r   <= bk4_side_r.hum;
  end

  assign out_valid          = out_vld_r;
  assign out_temp_centi     = out_temp_r;
  assign out_pressure_pa    = out_press_r;
  assign out_humidity_centi = out_hum_r;

`ifndef SYNTH
  // every result traces back to one accepted word a fixed latency earlier
  a_out_from_in: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start && !busy, PipeLat))
    else $error("result without a matching input word");

  // divider keeps its word count and timing
  a_div_lat: assert property (@(posedge clk) disable iff (!rst_n)
    div_vld |-> $past(fv_r[FrontStages-1], DivBits))
    else $error("divider valid out of step");

  // clamped humidity never exceeds full scale
  a_hum_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_humidity_centi <= 14'd10000))
    else $error("humidity above full scale");
`endif

endmodule

// ===== verif/pth_sensor_compensation_tb.sv =====
// self-checking testbench of the pth integer compensation pipeline
`timescale 1ns / 100ps

module pth_sensor_compensation_tb;
  import pthc_pkg::*;

  typedef struct packed {
    logic signed [15:0] temp;
    logic [31:0]        press;
    logic [13:0]        hum;
  } reading_t;

  typedef struct {
    logic [19:0] raw_p;
    logic [19:0] raw_t;
    logic [15:0] raw_h;
    bit          known;
    reading_t    want;
  } sample_row_t;

  logic               clk = 1'b0;
  logic               rst_n;
  logic               start;
  logic               busy;
  logic [19:0]        in_raw_pressure;
  logic [19:0]        in_raw_temperature;
  logic [15:0]        in_raw_humidity;
  logic               out_valid;
  logic signed [15:0] out_temp_centi;
  logic [31:0]        out_pressure_pa;
  logic [13:0]        out_humidity_centi;
  logic               cfg_valid;
  logic               cfg_ready;
  cfg_reg_t           cfg_index;
  logic [63:0]        cfg_data;

  // calibration copy held by the predictor
  bit [63:0] cal_q [5];
  reading_t  readings_due [$];
  int        err_cnt = 0;
  bit        row_known;
  reading_t  row_want;
  bit        no_gaps;

  // a typical factory calibration
  localparam logic [63:0] TypTemp  = {16'h0, -16'sd1000, 16'sd26435, 16'd27504};
  localparam logic [63:0] TypPressA = {16'sd2855, 16'sd3024, -16'sd10685, 16'd36477};
  localparam logic [63:0] TypPressB = {-16'sd14600, 16'sd15500, -16'sd7, 16'sd140};
  localparam logic [63:0] TypP9    = 64'd6000;
  localparam logic [63:0] TypHum   = {8'sd30, 12'sd50, 12'sd324, 8'd0, 16'sd362, 8'd75};

  pth_sensor_compensation i_dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .start              (start),
    .busy               (busy),
    .in_raw_pressure    (in_raw_pressure),
    .in_raw_temperature (in_raw_temperature),
    .in_raw_humidity    (in_raw_humidity),
    .out_valid          (out_valid),
    .out_temp_centi     (out_temp_centi),
    .out_pressure_pa    (out_pressure_pa),
    .out_humidity_centi (out_humidity_centi),
    .cfg_valid          (cfg_valid),
    .cfg_ready          (cfg_ready),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data)
  );

  always #5 clk = ~clk;

  function automatic bit [31:0] asr32(bit [31:0] x, int n);
    return $unsigned($signed(x) >>> n);
  endfunction

  function automatic bit [63:0] asr64(bit [63:0] x, int n);
    return $unsigned($signed(x) >>> n);
  endfunction

  // signed divide truncating toward zero, most negative / -1 wraps
  function automatic bit [63:0] sdiv64(bit [63:0] n, bit [63:0] d);
    bit [63:0] an;
    bit [63:0] ad;
    bit [63:0] q;
    an = n[63] ? 64'd0 - n : n;
    ad = d[63] ? 64'd0 - d : d;
    q  = an / ad;
    return (n[63] != d[63]) ? 64'd0 - q : q;
  endfunction

  // integer compensation of one sample with the current calibration
  function automatic reading_t compensate(logic [19:0] rp, logic [19:0] rt, logic [15:0] rh);
    bit [31:0] t1, t2, t3, a, b, tv1, tv2, tf, tc;
    bit [63:0] p1, p2, p3, p4, p5, p6, p7, p8, p9, v1, v2, pp, e1, e2;
    bit [31:0] h1, h2, h3, h4, h5, h6, v, x, y, z, w;
    reading_t  r;
    // temperature
    t1  = {16'b0, cal_q[CFG_TEMP][15:0]};
    t2  = 32'($signed(cal_q[CFG_TEMP][31:16]));
    t3  = 32'($signed(cal_q[CFG_TEMP][47:32]));
    a   = ({12'b0, rt} >> 3) - (t1 << 1);
    tv1 = asr32(a * t2, 11);
    b   = ({12'b0, rt} >> 4) - t1;
    tv2 = asr32(asr32(b * b, 12) * t3, 14);
    tf  = tv1 + tv2;
    tc  = asr32(tf * 32'd5 + 32'd128, 8);
    r.temp = tc[15:0];
    // pressure
    p1 = {48'b0, cal_q[CFG_PRESS_A][15:0]};
    p2 = 64'($signed(cal_q[CFG_PRESS_A][31:16]));
    p3 = 64'($signed(cal_q[CFG_PRESS_A][47:32]));
    p4 = 64'($signed(cal_q[CFG_PRESS_A][63:48]));
    p5 = 64'($signed(cal_q[CFG_PRESS_B][15:0]));
    p6 = 64'($signed(cal_q[CFG_PRESS_B][31:16]));
    p7 = 64'($signed(cal_q[CFG_PRESS_B][47:32]));
    p8 = 64'($signed(cal_q[CFG_PRESS_B][63:48]));
    p9 = 64'($signed(cal_q[CFG_PRESS_P9][15:0]));
    v1 = 64'($signed(tf)) - 64'd128000;
    v2 = v1 * v1 * p6;
    v2 = v2 + ((v1 * p5) << 17);
    v2 = v2 + (p4 << 35);
    v1 = asr64(v1 * v1 * p3, 8) + ((v1 * p2) << 12);
    v1 = asr64(((64'd1 << 47) + v1) * p1, 33);
    if (v1 == 64'd0) begin
      r.press = 32'd0;
    end else begin
      pp = 64'd1048576 - {44'b0, rp};
      pp = sdiv64(((pp << 31) - v2) * 64'd3125, v1);
      e1 = asr64(p9 * asr64(pp, 13) * asr64(pp, 13), 25);
      e2 = asr64(p8 * pp, 19);
      pp = asr64(pp + e1 + e2, 8) + (p7 << 4);
      pp = asr64(pp, 8);
      r.press = pp[31:0];
    end
    // humidity
    h1 = {24'b0, cal_q[CFG_HUM][7:0]};
    h2 = 32'($signed(cal_q[CFG_HUM][23:8]));
    h3 = {24'b0, cal_q[CFG_HUM][31:24]};
    h4 = 32'($signed(cal_q[CFG_HUM][43:32]));
    h5 = 32'($signed(cal_q[CFG_HUM][55:44]));
    h6 = 32'($signed(cal_q[CFG_HUM][63:56]));
    v = tf - 32'd76800;
    x = asr32(({16'b0, rh} << 14) - (h4 << 20) - (h5 * v) + 32'd16384, 15);
    y = asr32(v * h6, 10);
    z = asr32(v * h3, 11) + 32'd32768;
    w = asr32(y * z, 10) + 32'd2097152;
    w = asr32(w * h2 + 32'd8192, 14);
    v = x * w;
    v = v - asr32(asr32(asr32(v, 15) * asr32(v, 15), 7) * h1, 4);
    // clamp before scaling
    if (v[31]) v = 32'd0;
    else if (v > 32'd419430400) v = 32'd419430400;
    v = ((v >> 12) * 32'd100 + 32'd512) / 32'd1024;
    r.hum = v[13:0];
    return r;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    $display("%0t mismatch %s: got %0d want %0d", $realtime, what, got, want);
    err_cnt++;
  endtask

  // input words taken: queue the expected reading
  always @(posedge clk) begin
    if (rst_n && start && !busy) begin
      readings_due.push_back(row_known ? row_want
                             : compensate(in_raw_pressure, in_raw_temperature, in_raw_humidity));
    end
  end

  // result words: compare with the oldest expectation
  always @(posedge clk) begin
    reading_t exp_r;
    if (rst_n && out_valid) begin
      if (readings_due.size() == 0) begin
        report_mismatch("unexpected result word", 0, 0);
      end else begin
        exp_r = readings_due.pop_front();
        if (out_temp_centi !== exp_r.temp)
          report_mismatch("temp_centi", out_temp_centi, exp_r.temp);
        if (out_pressure_pa !== exp_r.press)
          report_mismatch("pressure_pa", out_pressure_pa, exp_r.press);
        if (out_humidity_centi !== exp_r.hum)
          report_mismatch("humidity_centi", out_humidity_centi, exp_r.hum);
      end
    end
  end

  function automatic int pick_gap();
    int r;
    if (no_gaps) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // called at a falling edge, returns at a falling edge
  task automatic send_sample(logic [19:0] rp, logic [19:0] rt, logic [15:0] rh);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      start = 1'b0;
      repeat (gap) @(negedge clk);
    end
    start              = 1'b1;
    in_raw_pressure    = rp;
    in_raw_temperature = rt;
    in_raw_humidity    = rh;
    do @(posedge clk); while (busy);
    @(negedge clk);
  endtask

  task automatic write_cal(cfg_reg_t idx, logic [63:0] value);
    int gap;
    gap = pick_gap();
    repeat (gap) @(negedge clk);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data  = value;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      CFG_TEMP:     cal_q[idx] = value & 64'hFFFF_FFFF_FFFF;
      CFG_PRESS_P9: cal_q[idx] = value & 64'hFFFF;
      default:      cal_q[idx] = value;
    endcase
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic program_cal(logic [63:0] ct, logic [63:0] pa, logic [63:0] pb,
                             logic [63:0] p9, logic [63:0] ch);
    write_cal(CFG_TEMP, ct);
    write_cal(CFG_PRESS_A, pa);
    write_cal(CFG_PRESS_B, pb);
    write_cal(CFG_PRESS_P9, p9);
    write_cal(CFG_HUM, ch);
  endtask

  // wait until the pipeline has drained
  task automatic drain();
    start = 1'b0;
    while (readings_due.size() != 0) @(negedge clk);
    repeat (PipeLat + 10) @(negedge clk);
  endtask

  function automatic logic [19:0] pick20(bit realistic, int lo, int hi);
    int r;
    if (realistic) return 20'($urandom_range(lo, hi));
    r = $urandom_range(0, 9);
    if (r == 0) return 20'd0;
    if (r == 1) return 20'hFFFFF;
    return 20'($urandom);
  endfunction

  // directed samples; rows with known results run at the reset calibration
  localparam int NumKnown = 5;
  sample_row_t directed [] = '{
    '{20'd0,       20'd0,       16'd0,      1'b1, '0},
    '{20'hFFFFF,   20'hFFFFF,   16'hFFFF,   1'b1, '0},
    '{20'hAAAAA,   20'h55555,   16'hAAAA,   1'b1, '0},
    '{20'h55555,   20'hAAAAA,   16'h5555,   1'b1, '0},
    '{20'd415148,  20'd519888,  16'd30000,  1'b1, '0},
    '{20'd415148,  20'd519888,  16'd30000,  1'b0, '0},
    '{20'd0,       20'd519888,  16'd30000,  1'b0, '0},
    '{20'hFFFFF,   20'd519888,  16'd30000,  1'b0, '0},
    '{20'd415148,  20'd0,       16'd30000,  1'b0, '0},
    '{20'd415148,  20'hFFFFF,   16'd30000,  1'b0, '0},
    '{20'd415148,  20'd519888,  16'd0,      1'b0, '0},
    '{20'd415148,  20'd519888,  16'hFFFF,   1'b0, '0},
    '{20'd300000,  20'd440000,  16'd60000,  1'b0, '0},
    '{20'd550000,  20'd600000,  16'd1000,   1'b0, '0},
    '{20'hFFFFF,   20'hFFFFF,   16'hFFFF,   1'b0, '0},
    '{20'd0,       20'd0,       16'd0,      1'b0, '0}
  };

  initial begin
    bit realistic;
    start              = 1'b0;
    in_raw_pressure    = '0;
    in_raw_temperature = '0;
    in_raw_humidity    = '0;
    cfg_valid          = 1'b0;
    cfg_index          = CFG_TEMP;
    cfg_data           = '0;
    row_known          = 1'b0;
    row_want           = '0;
    no_gaps            = 1'b0;
    foreach (cal_q[i]) cal_q[i] = '0;
    rst_n = 1'b0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // directed table
    foreach (directed[i]) begin
      if (i == NumKnown) begin
        drain();
        program_cal(TypTemp, TypPressA, TypPressB, TypP9, TypHum);
      end
      row_known = directed[i].known;
      row_want  = directed[i].want;
      send_sample(directed[i].raw_p, directed[i].raw_t, directed[i].raw_h);
    end
    row_known = 1'b0;

    // random phases, each with its own calibration
    for (int ph = 0; ph < 8; ph++) begin
      drain();
      case (ph)
        0: program_cal(TypTemp, TypPressA, TypPressB, TypP9, TypHum);
        1: program_cal('1, '1, '1, '1, '1);
        2: program_cal('0, '0, '0, '0, '0);
        3: program_cal(TypTemp ^ 64'($urandom_range(0, 255)),
                       TypPressA ^ 64'($urandom_range(0, 255)),
                       TypPressB ^ 64'($urandom_range(0, 255)),
                       TypP9 ^ 64'($urandom_range(0, 255)),
                       TypHum ^ 64'($urandom_range(0, 255)));
        4: program_cal({32'h0000_8000, 32'h8000_FFFF}, {48'h8000_8000_8000, 16'hFFFF},
                       64'h8000_8000_8000_8000, 64'h8000, 64'h8080_0800_FF80_00FF);
        default: program_cal({$urandom, $urandom}, {$urandom, $urandom},
                             {$urandom, $urandom}, {$urandom, $urandom},
                             {$urandom, $urandom});
      endcase
      no_gaps = (ph == 2 || ph == 5);
      repeat (250) begin
        realistic = ($urandom_range(0, 9) < 7);
        send_sample(pick20(realistic, 200000, 600000),
                    pick20(realistic, 400000, 600000),
                    realistic ? 16'($urandom_range(15000, 50000)) : 16'($urandom));
      end
    end

    drain();
    if (err_cnt == 0) begin
      $display("pth_sensor_compensation_tb: clean");
    end else begin
      $display("pth_sensor_compensation_tb: errors");
    end
    $finish;
  end

  // run limit
  initial begin
    #20ms;
    $display("pth_sensor_compensation_tb: errors");
    $finish;
  end

endmodule

// ===== pth_sensor_compensation.f =====
rtl/core/pthc_pkg.sv
rtl/core/pthc_div.sv
rtl/core/pth_sensor_compensation.sv
verif/pth_sensor_compensation_tb.sv
